FILE: sv/rrpt_pkg.sv
`timescale 1ns / 1ps
// Package: request codes, controller states and the types passed along the cell chain.
package rrpt_pkg;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SUB   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_TEST  = 2'd3
    } t_req_type;

    typedef enum logic {
        ST_IDLE,
        ST_TEST
    } t_state;

    // Rectangle as held in a cell: inclusive start, exclusive end, whole units.
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [16:0] x1;
        logic signed [16:0] y1;
        logic               sub;
    } t_rect;

    // Query token moving one cell per cycle.
    typedef struct packed {
        logic               vld;
        logic               acc;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } t_token;

endpackage

FILE: sv/rrpt_if.sv
`timescale 1ns / 1ps
// Interfaces: request and response channels with valid/ready handshake.
interface rrpt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;

    modport source (output valid, output req_type, output pos_x, output pos_y,
                    output rect_width, output rect_height, input ready);
    modport sink   (input valid, input req_type, input pos_x, input pos_y,
                    input rect_width, input rect_height, output ready);
endinterface

interface rrpt_rsp_if #(
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic             status;
    logic [CNT_W-1:0] entries_used;

    modport source (output valid, output inside_res, output status,
                    output entries_used, input ready);
    modport sink   (input valid, input inside_res, input status,
                    input entries_used, output ready);
endinterface

FILE: sv/rrpt_cell.sv
`timescale 1ns / 1ps
// One list entry: stores a rectangle and updates the passing query token.
module rrpt_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  rrpt_pkg::t_rect      i_rect,
    input  logic [CNT_W-1:0]     i_count,
    input  rrpt_pkg::t_token     i_tok,
    output rrpt_pkg::t_token     o_tok
);

    rrpt_pkg::t_rect  r_rect;
    rrpt_pkg::t_token r_tok;
    rrpt_pkg::t_token n_tok;
    logic             live;
    logic             hit;

    // entry is part of the list only below the current count
    assign live = (i_count > CNT_W'(CELL_IDX));

    always_comb begin
        hit = ($signed(i_tok.px) >= $signed(r_rect.x0)) &&
              ($signed(i_tok.py) >= $signed(r_rect.y0)) &&
              ($signed({i_tok.px[15], i_tok.px}) < $signed(r_rect.x1)) &&
              ($signed({i_tok.py[15], i_tok.py}) < $signed(r_rect.y1));
        n_tok = i_tok;
        if (live && hit) begin
            n_tok.acc = ~r_rect.sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IDX_W'(CELL_IDX))) begin
            r_rect <= i_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/rect_region_point_test_top.sv
`timescale 1ns / 1ps
// Top level: rectangle list point-in-region tester built as a chain of cells.
// Usage
//   i_req carries one request per item: append an add rectangle, append a
//   subtract rectangle, clear the list, or test a point. o_rsp returns exactly
//   one item per request: inside_res (point tests only), status (1 when an
//   append hit a full list and was dropped) and entries_used after the request.
//   Each list entry lives in its own cell. A point test enters cell 0 as a
//   token and moves one cell per clock; each live cell that holds the point
//   overwrites the running answer, so the last matching entry decides.
// Sequencing
//   Append and clear: response valid in the cycle after acceptance; with the
//   receiver ready they stream at one item per cycle.
//   Point test: the token walks all MAX_OPS cells, then its answer is registered
//   as the response; no new item is taken while the token is in the chain.
// Reset
//   Synchronous, active low: the list becomes empty, no token is in flight,
//   no response is pending. Stored rectangles are not cleared.
// Stall
//   The response register holds until taken; while it is full and not being
//   taken, i_req.ready stays low. Only one request is in work at a time.
module rect_region_point_test_top #(
    parameter int MAX_OPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrpt_req_if.sink   i_req,
    rrpt_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(MAX_OPS + 1);
    localparam int IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

    rrpt_pkg::t_state  r_state;
    rrpt_pkg::t_state  n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_out_vld;
    logic              n_out_vld;
    logic              r_inside;
    logic              n_inside;
    logic              r_status;
    logic              n_status;
    logic [CNT_W-1:0]  r_entries;
    logic [CNT_W-1:0]  n_entries;

    logic              accept;
    logic              full;
    logic              wr_en;
    rrpt_pkg::t_rect   wr_rect;
    rrpt_pkg::t_token  tok [0:MAX_OPS];
    rrpt_pkg::t_req_type req;

    assign req    = rrpt_pkg::t_req_type'(i_req.req_type);
    assign full   = (r_count == CNT_W'(MAX_OPS));
    assign i_req.ready = (r_state == rrpt_pkg::ST_IDLE) && (!r_out_vld || o_rsp.ready);
    assign accept = i_req.valid && i_req.ready;

    // rectangle edges: fraction bits dropped (floor), end edge = start + size
    always_comb begin
        wr_rect.x0  = i_req.pos_x[23:8];
        wr_rect.y0  = i_req.pos_y[23:8];
        wr_rect.x1  = $signed({i_req.pos_x[23], i_req.pos_x[23:8]}) +
                      $signed({i_req.rect_width[15], i_req.rect_width});
        wr_rect.y1  = $signed({i_req.pos_y[23], i_req.pos_y[23:8]}) +
                      $signed({i_req.rect_height[15], i_req.rect_height});
        wr_rect.sub = (req == rrpt_pkg::REQ_SUB);
    end

    // query token injected at the head of the chain
    always_comb begin
        tok[0].vld = accept && (req == rrpt_pkg::REQ_TEST);
        tok[0].acc = 1'b0;
        tok[0].px  = i_req.pos_x[23:8];
        tok[0].py  = i_req.pos_y[23:8];
    end

    for (genvar g = 0; g < MAX_OPS; g++) begin : g_cell
        rrpt_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (wr_en),
            .i_wr_idx (r_count[IDX_W-1:0]),
            .i_rect   (wr_rect),
            .i_count  (r_count),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    // controller: request decode, list count, response register
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_out_vld = r_out_vld;
        n_inside  = r_inside;
        n_status  = r_status;
        n_entries = r_entries;
        wr_en     = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            rrpt_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req) inside
                        rrpt_pkg::REQ_ADD, rrpt_pkg::REQ_SUB: begin
                            n_out_vld = 1'b1;
                            n_inside  = 1'b0;
                            n_status  = full;
                            if (!full) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                            n_entries = full ? r_count : r_count + CNT_W'(1);
                        end
                        rrpt_pkg::REQ_CLEAR: begin
                            n_out_vld = 1'b1;
                            n_inside  = 1'b0;
                            n_status  = 1'b0;
                            n_count   = '0;
                            n_entries = '0;
                        end
                        rrpt_pkg::REQ_TEST: begin
                            n_state = rrpt_pkg::ST_TEST;
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            rrpt_pkg::ST_TEST: begin
                if (tok[MAX_OPS].vld) begin
                    n_state   = rrpt_pkg::ST_IDLE;
                    n_out_vld = 1'b1;
                    n_inside  = tok[MAX_OPS].acc;
                    n_status  = 1'b0;
                    n_entries = r_count;
                end
            end
            default: begin
                n_state = rrpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrpt_pkg::ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside  <= n_inside;
        r_status  <= n_status;
        r_entries <= n_entries;
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.inside_res   = r_inside;
    assign o_rsp.status       = r_status;
    assign o_rsp.entries_used = r_entries;

endmodule

FILE: tb/tb_rect_region_point_test_top.sv
`timescale 1ns / 1ps
// Testbench for the rectangle list point-in-region tester: directed and random items.
module tb_rect_region_point_test_top;

    localparam int MAX_OPS        = 16;
    localparam int CNT_W          = 5;
    // The slowest legal stretch with no handshake is a sender gap, a point
    // test walking all cells, then a receiver stall.
    localparam int WATCHDOG_LIMIT = 1000;

    // One response item as the block should return it.
    typedef struct packed {
        logic             in_region;
        logic             status;
        logic [CNT_W-1:0] entries;
    } t_region_answer;

    logic i_clk;
    logic i_rst_n;

    rrpt_req_if                  req_if ();
    rrpt_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

    rect_region_point_test_top #(.MAX_OPS(MAX_OPS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predictor copy of the operation list: whole-unit origin, size, kind.
    logic signed [15:0] held_x0  [MAX_OPS];
    logic signed [15:0] held_y0  [MAX_OPS];
    logic signed [15:0] held_w   [MAX_OPS];
    logic signed [15:0] held_h   [MAX_OPS];
    logic               held_sub [MAX_OPS];
    int                 held_count;

    t_region_answer answers_due[$];   // answers still owed by the block, oldest first
    int             error_count;
    int             items_sent;
    int             gap_pct;          // chance per item that the sender idles first
    int             stall_pct;        // chance per cycle that the receiver stalls

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted request to the list and return the
    // answer. A point test replays the list; the last holding rectangle wins.
    // ------------------------------------------------------------------
    function automatic t_region_answer predict_region_answer(
        input rrpt_pkg::t_req_type kind,
        input logic signed [23:0]  x,
        input logic signed [23:0]  y,
        input logic signed [15:0]  w,
        input logic signed [15:0]  h
    );
        t_region_answer ans;
        int px, py, x0, y0, xe, ye;
        ans = '0;
        case (kind) inside
            rrpt_pkg::REQ_ADD, rrpt_pkg::REQ_SUB: begin
                if (held_count >= MAX_OPS) begin
                    ans.status = 1'b1;    // full list: append dropped
                end else begin
                    // fraction bits dropped, edge rounds toward minus infinity
                    held_x0[held_count]  = x[23:8];
                    held_y0[held_count]  = y[23:8];
                    held_w[held_count]   = w;
                    held_h[held_count]   = h;
                    held_sub[held_count] = (kind == rrpt_pkg::REQ_SUB);
                    held_count++;
                end
            end
            rrpt_pkg::REQ_CLEAR: begin
                held_count = 0;
            end
            default: begin
                px = x;
                py = y;
                for (int i = 0; i < held_count; i++) begin
                    x0 = held_x0[i];
                    y0 = held_y0[i];
                    xe = x0 + int'(held_w[i]);
                    ye = y0 + int'(held_h[i]);
                    // end is exclusive, so zero or negative sizes hold nothing
                    if (px >= x0 * 256 && px < xe * 256 && py >= y0 * 256 && py < ye * 256)
                        ans.in_region = !held_sub[i];
                end
            end
        endcase
        ans.entries = held_count[CNT_W-1:0];
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one item; valid stays high on return so the next item can follow
    // back to back. The expectation is queued at the accepting edge.
    task automatic send_request(
        input rrpt_pkg::t_req_type kind,
        input logic [23:0]         x,
        input logic [23:0]         y,
        input logic [15:0]         w,
        input logic [15:0]         h
    );
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.req_type    = kind;
        req_if.pos_x       = x;
        req_if.pos_y       = y;
        req_if.rect_width  = w;
        req_if.rect_height = h;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        answers_due.push_back(predict_region_answer(kind, x, y, w, h));
        items_sent++;
    endtask

    // Sender holds off until every owed answer has come back.
    task automatic wait_for_drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // Rectangle edge: mostly a small window around the origin so that
    // rectangles overlap, sometimes anywhere in the 24-bit range.
    function automatic logic [23:0] random_edge();
        int whole, v;
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        whole = $urandom_range(0, 80);
        whole = whole - 40;
        v = whole * 256 + int'($urandom_range(0, 255));
        return v[23:0];
    endfunction

    // Rectangle size: mostly small positive, some empty, some anything.
    function automatic logic [15:0] random_size();
        int r, s;
        r = $urandom_range(0, 19);
        if (r < 14)
            return 16'($urandom_range(1, 40));
        if (r < 17) begin
            s = $urandom_range(0, 3);
            s = -s;
            return s[15:0];
        end
        return 16'($urandom);
    endfunction

    // Query coordinate close to one axis of a held rectangle: on either
    // edge, one LSB outside it, or somewhere in between.
    function automatic logic [23:0] near_edge(input logic signed [15:0] o,
                                              input logic signed [15:0] s);
        int ov, sv, base;
        ov = o;
        sv = s;
        case ($urandom_range(0, 5))
            0:       base = ov * 256;
            1:       base = ov * 256 - 1;
            2:       base = (ov + sv) * 256;
            3:       base = (ov + sv) * 256 - 1;
            4:       base = ov * 256 + int'($urandom_range(0, 255));
            default: begin
                if (sv > 0)
                    base = ov * 256 + int'($urandom_range(0, sv * 256 - 1));
                else
                    base = ov * 256 - int'($urandom_range(0, 512));
            end
        endcase
        return base[23:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty list, inclusive/exclusive edges, fraction handling on edges,
    // subtract overriding add, empty sizes, coordinate extremes.
    task automatic test_empty_and_edges();
        gap_pct   = 30;
        stall_pct = 20;
        // empty list
        send_request(rrpt_pkg::REQ_TEST, 24'h000000, 24'h000000, 16'h0000, 16'h0000);
        // [0,4)x[0,4)
        send_request(rrpt_pkg::REQ_ADD,  24'h000080, 24'h0000FF, 16'd4, 16'd4);
        // top-left corner
        send_request(rrpt_pkg::REQ_TEST, 24'h000000, 24'h000000, 16'h0000, 16'h0000);
        // last LSB inside
        send_request(rrpt_pkg::REQ_TEST, 24'h0003FF, 24'h0003FF, 16'h0000, 16'h0000);
        // right edge out
        send_request(rrpt_pkg::REQ_TEST, 24'h000400, 24'h000000, 16'h0000, 16'h0000);
        // just left of the left edge
        send_request(rrpt_pkg::REQ_TEST, 24'hFFFFFF, 24'h000100, 16'h0000, 16'h0000);
        // hole [1,3)x[1,3)
        send_request(rrpt_pkg::REQ_SUB,  24'h000100, 24'h000100, 16'd2, 16'd2);
        send_request(rrpt_pkg::REQ_TEST, 24'h000180, 24'h000200, 16'h0000, 16'h0000);
        // refill [1,2)
        send_request(rrpt_pkg::REQ_ADD,  24'h0001FF, 24'h0001C0, 16'd1, 16'd1);
        send_request(rrpt_pkg::REQ_TEST, 24'h000100, 24'h0001FF, 16'h0000, 16'h0000);
        // zero width
        send_request(rrpt_pkg::REQ_ADD,  24'h000000, 24'h000000, 16'd0, 16'd5);
        // negative size
        send_request(rrpt_pkg::REQ_ADD,  24'h000000, 24'h000000, 16'h8000, 16'hFFFF);
        send_request(rrpt_pkg::REQ_TEST, 24'h000000, 24'h000000, 16'h0000, 16'h0000);
        // most negative
        send_request(rrpt_pkg::REQ_ADD,  24'h800000, 24'h800000, 16'h7FFF, 16'h7FFF);
        send_request(rrpt_pkg::REQ_TEST, 24'h800000, 24'h800000, 16'h0000, 16'h0000);
        // floors to -1
        send_request(rrpt_pkg::REQ_SUB,  24'hFFFFFF, 24'hFFFFFF, 16'd1, 16'd1);
        send_request(rrpt_pkg::REQ_TEST, 24'hFFFF00, 24'hFFFFFF, 16'h0000, 16'h0000);
        // end past 16 bits
        send_request(rrpt_pkg::REQ_ADD,  24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'd1);
        send_request(rrpt_pkg::REQ_TEST, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Fill the list, append of both kinds to the full list, then clear.
    task automatic test_full_list();
        while (held_count < MAX_OPS)
            send_request(rrpt_pkg::REQ_ADD, 24'h000A00, 24'h000A00, 16'd1, 16'd1);
        // both dropped
        send_request(rrpt_pkg::REQ_ADD,   24'h000000, 24'h000000, 16'd8, 16'd8);
        send_request(rrpt_pkg::REQ_SUB,   24'h000000, 24'h000000, 16'd8, 16'd8);
        send_request(rrpt_pkg::REQ_TEST,  24'h000A80, 24'h000A80, 16'h0000, 16'h0000);
        send_request(rrpt_pkg::REQ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        // cleared
        send_request(rrpt_pkg::REQ_TEST,  24'h000A80, 24'h000A80, 16'h0000, 16'h0000);
    endtask

    // Mostly well-formed sequences: optional clear, a run of appends, then
    // point tests aimed at the edges of held rectangles. The rest is noise.
    task automatic test_random_regions(input int n_items, input int gap, input int stall);
        int stop_at, n_rects, n_tests, idx;
        logic [23:0] qx, qy;
        gap_pct   = gap;
        stall_pct = stall;
        stop_at   = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                send_request(rrpt_pkg::t_req_type'($urandom_range(0, 3)),
                             24'($urandom), 24'($urandom),
                             16'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(0, 2) != 0)
                    send_request(rrpt_pkg::REQ_CLEAR, 24'($urandom), 24'($urandom),
                                 16'($urandom), 16'($urandom));
                // occasional long runs push the list into overflow
                n_rects = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18)
                                                      : $urandom_range(1, 5);
                repeat (n_rects)
                    send_request(($urandom_range(0, 3) == 0) ? rrpt_pkg::REQ_SUB
                                                             : rrpt_pkg::REQ_ADD,
                                 random_edge(), random_edge(), random_size(), random_size());
                n_tests = $urandom_range(1, 6);
                repeat (n_tests) begin
                    if (held_count == 0) begin
                        qx = random_edge();
                        qy = random_edge();
                    end else begin
                        idx = $urandom_range(0, held_count - 1);
                        qx  = near_edge(held_x0[idx], held_w[idx]);
                        qy  = near_edge(held_y0[idx], held_h[idx]);
                    end
                    send_request(rrpt_pkg::REQ_TEST, qx, qy, 16'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready drops in random bursts while stall_pct is nonzero.
    // ------------------------------------------------------------------
    initial begin
        rsp_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Response checker: each accepted item against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    initial begin
        t_region_answer want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (answers_due.size() == 0) begin
                    $error("response item with no request outstanding");
                    error_count++;
                end else begin
                    want = answers_due.pop_front();
                    compare_field("inside_res",   want.in_region, rsp_if.inside_res);
                    compare_field("status",       want.status,    rsp_if.status);
                    compare_field("entries_used", want.entries,   rsp_if.entries_used);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no handshake on either side ends the run.
    // ------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        error_count        = 0;
        items_sent         = 0;
        held_count         = 0;
        gap_pct            = 0;
        stall_pct          = 0;
        req_if.valid       = 1'b0;
        req_if.req_type    = rrpt_pkg::REQ_ADD;
        req_if.pos_x       = '0;
        req_if.pos_y       = '0;
        req_if.rect_width  = '0;
        req_if.rect_height = '0;
        i_rst_n            = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_edges();
        test_full_list();
        wait_for_drain();                 // sender pauses until all answers are back
        test_random_regions(700, 20, 15);
        wait_for_drain();
        test_random_regions(700, 45, 25); // heavy idling on both sides
        test_random_regions(450, 0, 0);   // closing stretch: full rate, no idling

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        // let any stray response surface: a point test walks all MAX_OPS cells
        repeat (MAX_OPS + 8) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
